// ===== src/str_pkg.sv =====
`timescale 1ns / 1ps

package str_pkg;

	localparam int TIME_BITS = 48;
	localparam int CFG_BITS = 32;
	localparam int SPEED_BITS = 16;
	localparam int FRAC_BITS = 8;
	localparam int STEP_BITS = 16;
	localparam int OP_BITS = 3;
	localparam int STATUS_BITS = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
	localparam int PROD_BITS = TIME_BITS + SPEED_BITS;

	localparam logic [OP_BITS-1:0] OP_SAMPLE = 3'd0;
	localparam logic [OP_BITS-1:0] OP_RESTART = 3'd1;
	localparam logic [OP_BITS-1:0] OP_SET_TIME = 3'd2;
	localparam logic [OP_BITS-1:0] OP_PAUSE = 3'd3;
	localparam logic [OP_BITS-1:0] OP_RESUME = 3'd4;
	localparam logic [OP_BITS-1:0] OP_STEP = 3'd5;

	localparam logic [STATUS_BITS-1:0] ST_ADVANCED = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOT_DUE = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_PAUSED = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_NEGATIVE = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_ZERO = 3'd4;
	localparam logic [STATUS_BITS-1:0] ST_DONE = 3'd5;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SLEEP_PERIOD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_EVAL_PERIOD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIM_STEP = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED = 2'd3;

	localparam logic [SPEED_BITS-1:0] SPEED_RESET = 16'd256;

	typedef struct packed {
		logic [OP_BITS-1:0]   operation;
		logic [TIME_BITS-1:0] time_value;
		logic [STEP_BITS-1:0] step_count;
	} cmd_word_t;

	typedef struct packed {
		logic                   advanced;
		logic [STATUS_BITS-1:0] status;
		logic [TIME_BITS-1:0]   out_step;
		logic [TIME_BITS-1:0]   out_now;
	} res_word_t;

	typedef struct packed {
		logic [CFG_BITS-1:0]   sleep_period;
		logic [CFG_BITS-1:0]   eval_period;
		logic [CFG_BITS-1:0]   sim_step;
		logic [SPEED_BITS-1:0] speed;
	} cfg_t;

	// val: real delta after control, step after scaling, or new time on set_time
	typedef struct packed {
		logic                   set_time;
		logic                   advanced;
		logic [STATUS_BITS-1:0] status;
		logic [TIME_BITS-1:0]   val;
	} pipe_word_t;

endpackage

// ===== src/str_cfg.sv =====
`timescale 1ns / 1ps

module str_cfg import str_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sleep_period <= '0;
			cfg_q.eval_period <= '0;
			cfg_q.sim_step <= '0;
			cfg_q.speed <= SPEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_SLEEP_PERIOD: cfg_q.sleep_period <= cfg_data;
				CFG_EVAL_PERIOD:  cfg_q.eval_period <= cfg_data;
				CFG_SIM_STEP:     cfg_q.sim_step <= cfg_data;
				CFG_SPEED:        cfg_q.speed <= cfg_data[SPEED_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/str_ctrl.sv =====
`timescale 1ns / 1ps

module str_ctrl import str_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_word_t  cmd,
	output logic       s2_valid,
	input  logic       s2_stall,
	output pipe_word_t s2_word
);

	logic       vld_s1;
	cmd_word_t  cmd_s1;
	logic       vld_s2;
	pipe_word_t word_s2;

	logic                 started_q, pause_pend_q, resume_pend_q, paused_q;
	logic [TIME_BITS-1:0] origin_q, last_loop_q, base_q, eval_acc_q, pend_q;
	logic [STEP_BITS-1:0] steps_q;

	logic                 started_n, pause_pend_n, resume_pend_n, paused_n;
	logic [TIME_BITS-1:0] origin_n, last_loop_n, base_n, eval_acc_n, pend_n;
	logic [STEP_BITS-1:0] steps_n;
	pipe_word_t           w2;

	logic                 ld1, ld2, fire1;
	logic [TIME_BITS-1:0] tv, rel_time, dt, ea_sum, pend_sum;
	logic                 neg, zero_ok, due, steps_nz, paused_eval;

	assign ld2 = !vld_s2 || !s2_stall;
	assign fire1 = vld_s1 && ld2;
	assign ld1 = !vld_s1 || fire1;
	assign cmd_stall = !ld1;

	// base_q holds the last sample time, i.e. origin plus last loop time
	assign tv = cmd_s1.time_value;
	assign rel_time = started_q ? (tv - origin_q) : '0;
	assign dt = started_q ? (tv - base_q) : '0;
	assign neg = started_q && (rel_time < last_loop_q);
	assign zero_ok = (cfg.sleep_period == '0) && (cfg.eval_period == '0) &&
		(cfg.sim_step != '0);
	assign ea_sum = eval_acc_q + dt;
	assign pend_sum = pend_q + dt;
	assign due = (cfg.eval_period == '0) ||
		(CMP_BITS'(ea_sum) >= CMP_BITS'(cfg.eval_period));
	assign steps_nz = (steps_q != '0);
	assign paused_eval = (steps_nz || resume_pend_q) ? 1'b0 : (paused_q || pause_pend_q);

	always_comb begin
		started_n = started_q;
		pause_pend_n = pause_pend_q;
		resume_pend_n = resume_pend_q;
		paused_n = paused_q;
		origin_n = origin_q;
		last_loop_n = last_loop_q;
		base_n = base_q;
		eval_acc_n = eval_acc_q;
		pend_n = pend_q;
		steps_n = steps_q;
		w2.set_time = 1'b0;
		w2.advanced = 1'b0;
		w2.status = ST_DONE;
		w2.val = '0;
		unique case (cmd_s1.operation)
			OP_SAMPLE: begin
				started_n = 1'b1;
				if (!started_q) begin
					origin_n = tv;
				end
				last_loop_n = rel_time;
				base_n = tv;
				if (neg) begin
					w2.status = ST_NEGATIVE;
				end else if ((dt == '0) && !zero_ok) begin
					w2.status = ST_ZERO;
				end else if (!due) begin
					eval_acc_n = ea_sum;
					pend_n = pend_sum;
					w2.status = ST_NOT_DUE;
				end else begin
					eval_acc_n = (cfg.eval_period == '0) ? ea_sum : '0;
					pend_n = '0;
					paused_n = paused_eval;
					resume_pend_n = 1'b0;
					pause_pend_n = steps_nz;
					steps_n = steps_nz ? (steps_q - 1'b1) : steps_q;
					if (paused_eval) begin
						w2.status = ST_PAUSED;
					end else begin
						w2.advanced = 1'b1;
						w2.status = ST_ADVANCED;
						w2.val = pend_sum;
					end
				end
			end
			OP_RESTART: begin
				origin_n = tv;
				last_loop_n = '0;
				base_n = tv;
				started_n = 1'b1;
			end
			OP_SET_TIME: begin
				eval_acc_n = '0;
				w2.set_time = 1'b1;
				w2.val = tv;
			end
			OP_PAUSE:  pause_pend_n = 1'b1;
			OP_RESUME: resume_pend_n = 1'b1;
			OP_STEP:   steps_n = cmd_s1.step_count;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			started_q <= 1'b0;
			pause_pend_q <= 1'b0;
			resume_pend_q <= 1'b0;
			paused_q <= 1'b0;
			origin_q <= '0;
			last_loop_q <= '0;
			base_q <= '0;
			eval_acc_q <= '0;
			pend_q <= '0;
			steps_q <= '0;
		end else begin
			if (ld1) begin
				vld_s1 <= cmd_valid;
			end
			if (ld2) begin
				vld_s2 <= vld_s1;
			end
			if (fire1) begin
				started_q <= started_n;
				pause_pend_q <= pause_pend_n;
				resume_pend_q <= resume_pend_n;
				paused_q <= paused_n;
				origin_q <= origin_n;
				last_loop_q <= last_loop_n;
				base_q <= base_n;
				eval_acc_q <= eval_acc_n;
				pend_q <= pend_n;
				steps_q <= steps_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && cmd_valid) begin
			cmd_s1 <= cmd;
		end
		if (fire1) begin
			word_s2 <= w2;
		end
	end

	assign s2_valid = vld_s2;
	assign s2_word = word_s2;

endmodule

// ===== src/str_scale.sv =====
`timescale 1ns / 1ps

module str_scale import str_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       s2_valid,
	output logic       s2_stall,
	input  pipe_word_t s2_word,
	output logic       s3_valid,
	input  logic       s3_stall,
	output pipe_word_t s3_word
);

	logic                 vld_s3;
	pipe_word_t           word_s3;
	logic                 ld3;
	logic [PROD_BITS-1:0] prod;
	logic [TIME_BITS-1:0] step;
	pipe_word_t           w3;

	assign ld3 = !vld_s3 || !s3_stall;
	assign s2_stall = !ld3;

	// real delta times speed in 8.8, fraction dropped
	assign prod = PROD_BITS'(s2_word.val) * PROD_BITS'(cfg.speed);
	assign step = (cfg.sim_step != '0) ? TIME_BITS'(cfg.sim_step) :
		prod[TIME_BITS+FRAC_BITS-1:FRAC_BITS];

	always_comb begin
		w3 = s2_word;
		if (s2_word.advanced) begin
			w3.val = step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (ld3) begin
			vld_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld3 && s2_valid) begin
			word_s3 <= w3;
		end
	end

	assign s3_valid = vld_s3;
	assign s3_word = word_s3;

endmodule

// ===== src/str_out.sv =====
`timescale 1ns / 1ps

module str_out import str_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s3_valid,
	output logic       s3_stall,
	input  pipe_word_t s3_word,
	output logic       res_valid,
	input  logic       res_stall,
	output res_word_t  res
);

	logic                 vld_s4;
	res_word_t            res_s4;
	logic [TIME_BITS-1:0] now_q, now_n;
	logic                 ld4, fire3;

	assign ld4 = !vld_s4 || !res_stall;
	assign fire3 = ld4 && s3_valid;
	assign s3_stall = !ld4;

	always_comb begin
		now_n = now_q;
		if (s3_word.set_time) begin
			now_n = s3_word.val;
		end else if (s3_word.advanced) begin
			now_n = now_q + s3_word.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			now_q <= '0;
		end else begin
			if (ld4) begin
				vld_s4 <= s3_valid;
			end
			if (fire3) begin
				now_q <= now_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire3) begin
			res_s4.advanced <= s3_word.advanced;
			res_s4.status <= s3_word.status;
			res_s4.out_step <= s3_word.advanced ? s3_word.val : '0;
			res_s4.out_now <= now_n;
		end
	end

	assign res_valid = vld_s4;
	assign res = res_s4;

endmodule

// ===== src/sim_time_step_regulator.sv =====
// channel | valid     | stall     | word
// command | cmd_valid | cmd_stall | cmd (operation, time_value, step_count)
// result  | res_valid | res_stall | res (advanced, status, out_step, out_now)
// config  | cfg_we    | -         | cfg_idx, cfg_data
// One word per cycle while res_stall is low; a taken command passes through the
// input register, control stage, multiply stage and result register in turn.
// The multiply stage holds the step (real delta times speed, or sim_step when
// nonzero); output time is kept in the result stage.
// Reset clears all control and config state and empties the pipeline; speed resets to 1.0.
// Result stall freezes the result register; earlier stages keep filling
// until all four are full, then cmd_stall rises.
`timescale 1ns / 1ps

module sim_time_step_regulator import str_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  cmd_word_t               cmd,
	output logic                    res_valid,
	input  logic                    res_stall,
	output res_word_t               res,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	cfg_t       cfg;
	logic       s2_valid, s2_stall, s3_valid, s3_stall;
	pipe_word_t s2_word, s3_word;

	str_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	str_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.s2_valid  (s2_valid),
		.s2_stall  (s2_stall),
		.s2_word   (s2_word)
	);

	str_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s2_valid (s2_valid),
		.s2_stall (s2_stall),
		.s2_word  (s2_word),
		.s3_valid (s3_valid),
		.s3_stall (s3_stall),
		.s3_word  (s3_word)
	);

	str_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3_valid  (s3_valid),
		.s3_stall  (s3_stall),
		.s3_word   (s3_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== src/str_check.sv =====
`timescale 1ns / 1ps

module str_check import str_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_word_t res
);

	logic                 has_prev_q;
	logic [TIME_BITS-1:0] last_now_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_prev_q <= 1'b0;
			last_now_q <= '0;
		end else if (res_valid && !res_stall) begin
			has_prev_q <= 1'b1;
			last_now_q <= res.out_now;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result word changed");

	a_adv_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.advanced == (res.status == ST_ADVANCED)))
		else $error("advanced flag and status disagree");

	a_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.advanced |-> res.out_step == '0)
		else $error("nonzero step without advance");

	a_time_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_prev_q && res.advanced |->
		res.out_now == TIME_BITS'(last_now_q + res.out_step))
		else $error("output time does not follow previous time plus step");

endmodule

bind sim_time_step_regulator str_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);
